// ===== hw/rtl/smi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smi_pkg: shared types and constants for the servo move interpolator
// Command queue entry, command kinds, action and register codes, back-end
// sequencer states and the fixed-point constants of the angle and pulse math.
// ----------------------------------------------------------------------------
package smi_pkg;

  // Input action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_STAGE = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 1'd1;

  localparam logic [15:0] PULSE_MIN_RESET = 16'd500;
  localparam logic [15:0] PULSE_MAX_RESET = 16'd2500;

  // Angles are Q6 degrees
  localparam logic signed [15:0] ANGLE_HOME = 16'sd5760;
  localparam logic [13:0]        ANGLE_HOME_U = 14'd5760;
  localparam logic [13:0]        ANGLE_FULL = 14'd11520;

  // t = 1.0 in Q16
  localparam logic [16:0] T_ONE = 17'h10000;

  // Fraction divider: one quotient bit per step
  localparam int DIV_STEPS = 16;

  // Floor division by 11520 = 256 * 45: shift by 8, then reciprocal of 45.
  // Exact for magnitudes below 2^22.
  localparam logic [22:0] RECIP_MUL   = 23'd5965233;
  localparam int          RECIP_SHIFT = 28;
  localparam logic signed [23:0] RECIP_ROUND = 24'sd44;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_STAGE,
    CMD_START
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [2:0]         joint;
    logic signed [15:0] angle;
    logic [15:0]        dur;
    logic [31:0]        now;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STATUS,
    ST_DIV,
    ST_MUL_T,
    ST_CLAMP,
    ST_MUL_SPAN,
    ST_RECIP,
    ST_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/smi_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smi_front: input acceptance and classification
// Decodes the action, drops unused codes and out-of-range stage items, and
// pushes the remaining commands into the queue. Stalls while the queue is full
// and during reset.
// ----------------------------------------------------------------------------
module smi_front
  import smi_pkg::*;
#(
  parameter int JOINTS = 6
) (
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         action,
  input  wire logic [2:0]         joint,
  input  wire logic signed [15:0] angle,
  input  wire logic [15:0]        duration_ms,
  input  wire logic [31:0]        now_ms,
  input  wire logic               q_full,
  output logic                    q_push,
  output cmd_t                    q_cmd
);

  logic keep;

  // Classify the incoming transaction
  always_comb begin
    keep       = 1'b0;
    q_cmd.kind = CMD_TICK;
    case (action)
      ACT_TICK: begin
        keep = 1'b1;
      end
      ACT_STAGE: begin
        keep       = ({29'd0, joint} < 32'(JOINTS));
        q_cmd.kind = CMD_STAGE;
      end
      ACT_START: begin
        keep       = 1'b1;
        q_cmd.kind = CMD_START;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    q_cmd.joint = joint;
    q_cmd.angle = angle;
    q_cmd.dur   = duration_ms;
    q_cmd.now   = now_ms;
  end

  assign in_stall = q_full || rst;
  assign q_push   = in_valid && !q_full && keep && !rst;

endmodule
`default_nettype wire

// ===== hw/rtl/smi_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smi_fifo: command queue between front and back
// Small register queue; the head entry is presented combinationally.
// ----------------------------------------------------------------------------
module smi_fifo
  import smi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  output logic      head_valid,
  input  wire logic pop,
  output cmd_t      head_cmd
);

  cmd_t             mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && head_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && head_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign full       = (count == (QAW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rd_ptr];

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/smi_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smi_back: move execution and pulse generation
// Holds the joint stores, move timing and pulse range registers. A tick while
// moving runs the fraction divider once unless the move has ended, then walks
// the joints through interpolate, clamp and pulse-scale into the output register.
// ----------------------------------------------------------------------------
module smi_back
  import smi_pkg::*;
#(
  parameter int JOINTS = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // command queue head
  input  wire logic                 q_valid,
  input  cmd_t                      q_cmd,
  output logic                      q_pop,
  // configuration writes
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                joint_out,
  output logic [15:0]               pulse_us,
  output logic                      pulse_valid,
  output logic                      moving,
  output logic                      last
);

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int DCW = $clog2(DIV_STEPS);

  back_state_t state, state_next;

  // Joint stores
  logic signed [15:0] staged  [JOINTS];
  logic signed [15:0] start_a [JOINTS];
  logic signed [15:0] goal_a  [JOINTS];
  logic [13:0]        last_a  [JOINTS];

  logic [31:0] move_start;
  logic [15:0] move_dur;
  logic        busy;
  logic [15:0] pulse_min;
  logic [15:0] pulse_max;

  // Tick working registers
  logic [15:0]        rem;
  logic [15:0]        tq;
  logic               t_full;
  logic [DCW-1:0]     div_cnt;
  logic [JW-1:0]      jcnt;
  logic signed [34:0] prod;
  logic [13:0]        a_cl;
  logic signed [31:0] x;
  logic [45:0]        recip;
  logic               neg;

  logic        load_out;
  logic        jlast;
  logic [31:0] elapsed;
  logic        t_done;
  logic [16:0] div_sh;
  logic        div_ge;
  logic [16:0] t_val;
  logic signed [16:0] diff;
  logic signed [34:0] prod_next;
  logic signed [19:0] a_sum;
  logic [13:0]        a_next;
  logic signed [16:0] span;
  logic signed [31:0] x_next;
  logic signed [23:0] y;
  logic [22:0]        u;
  logic [45:0]        recip_next;
  logic [17:0]        q_mag;
  logic [15:0]        pulse_next;

  // Arithmetic for each step
  always_comb begin
    elapsed    = q_cmd.now - move_start;
    t_done     = (elapsed >= {16'd0, move_dur});
    div_sh     = {rem, 1'b0};
    div_ge     = (div_sh >= {1'b0, move_dur});
    t_val      = t_full ? T_ONE : {1'b0, tq};
    diff       = $signed({goal_a[jcnt][15], goal_a[jcnt]})
               - $signed({start_a[jcnt][15], start_a[jcnt]});
    prod_next  = diff * $signed({1'b0, t_val});
    a_sum      = $signed({{4{start_a[jcnt][15]}}, start_a[jcnt]})
               + $signed({prod[34], prod[34:16]});
    if (a_sum < 20'sd0) begin
      a_next = '0;
    end else if (a_sum > $signed({6'd0, ANGLE_FULL})) begin
      a_next = ANGLE_FULL;
    end else begin
      a_next = a_sum[13:0];
    end
    span       = $signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min});
    x_next     = span * $signed({1'b0, a_cl});
    // floor(x / 256), then floor division by 45 via the magnitude, rounded up if negative
    y          = $signed(x[31:8]);
    u          = y[23] ? 23'(RECIP_ROUND - y) : 23'(y);
    recip_next = u * RECIP_MUL;
    q_mag      = recip[45:RECIP_SHIFT];
    pulse_next = neg ? (pulse_min - q_mag[15:0]) : (pulse_min + q_mag[15:0]);
    jlast      = (jcnt == JW'(JOINTS - 1));
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.kind == CMD_TICK) begin
            if (!busy) begin
              state_next = ST_STATUS;
            end else if (t_done) begin
              state_next = ST_MUL_T;
            end else begin
              state_next = ST_DIV;
            end
          end
        end
      end
      ST_STATUS: begin
        load_out = !out_valid || !out_stall;
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_cnt == DCW'(DIV_STEPS - 1)) begin
          state_next = ST_MUL_T;
        end
      end
      ST_MUL_T: begin
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_next = ST_MUL_SPAN;
      end
      ST_MUL_SPAN: begin
        state_next = ST_RECIP;
      end
      ST_RECIP: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        load_out = !out_valid || !out_stall;
        if (load_out) begin
          state_next = jlast ? ST_IDLE : ST_MUL_T;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state, stores and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < JOINTS; j++) begin
        staged[j]  <= ANGLE_HOME;
        start_a[j] <= ANGLE_HOME;
        goal_a[j]  <= ANGLE_HOME;
        last_a[j]  <= ANGLE_HOME_U;
      end
      move_start <= '0;
      move_dur   <= 16'd1;
      busy       <= 1'b0;
      pulse_min  <= PULSE_MIN_RESET;
      pulse_max  <= PULSE_MAX_RESET;
      out_valid  <= 1'b0;
      jcnt       <= '0;
      div_cnt    <= '0;
      t_full     <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid) begin
        case (cfg_index)
          REG_PULSE_MIN: pulse_min <= cfg_data;
          REG_PULSE_MAX: pulse_max <= cfg_data;
          default: ;
        endcase
      end

      // command dispatch
      if (q_pop) begin
        case (q_cmd.kind)
          CMD_STAGE: begin
            staged[JW'(q_cmd.joint)] <= q_cmd.angle;
          end
          CMD_START: begin
            for (int j = 0; j < JOINTS; j++) begin
              start_a[j] <= $signed({2'b00, last_a[j]});
              goal_a[j]  <= staged[j];
            end
            move_start <= q_cmd.now;
            move_dur   <= (q_cmd.dur == 16'd0) ? 16'd1 : q_cmd.dur;
            busy       <= 1'b1;
          end
          CMD_TICK: begin
            if (busy) begin
              t_full  <= t_done;
              busy    <= !t_done;
              div_cnt <= '0;
              jcnt    <= '0;
            end
          end
          default: ;
        endcase
      end

      if (state == ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (state == ST_CLAMP) begin
        last_a[jcnt] <= a_next;
      end
      if (state == ST_EMIT && load_out && !jlast) begin
        jcnt <= jcnt + 1'b1;
      end

      // output register
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem <= elapsed[15:0];
      tq  <= '0;
    end else if (state == ST_DIV) begin
      rem <= div_ge ? 16'(div_sh - {1'b0, move_dur}) : div_sh[15:0];
      tq  <= {tq[14:0], div_ge};
    end
    if (state == ST_MUL_T) begin
      prod <= prod_next;
    end
    if (state == ST_CLAMP) begin
      a_cl <= a_next;
    end
    if (state == ST_MUL_SPAN) begin
      x <= x_next;
    end
    if (state == ST_RECIP) begin
      recip <= recip_next;
      neg   <= y[23];
    end
    if (load_out) begin
      if (state == ST_STATUS) begin
        joint_out   <= '0;
        pulse_us    <= '0;
        pulse_valid <= 1'b0;
        moving      <= 1'b0;
        last        <= 1'b1;
      end else begin
        joint_out   <= 3'(jcnt);
        pulse_us    <= pulse_next;
        pulse_valid <= 1'b1;
        moving      <= busy;
        last        <= jlast;
      end
    end
  end

`ifndef SYNTH
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pulse_valid) |-> (last && !moving && joint_out == 3'd0))
    else $error("idle status result malformed");

  a_div_only_partial: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (!t_full && busy))
    else $error("divider running on a completed move");

  a_jcnt_range: assert property (@(posedge clk) disable iff (rst)
    jcnt <= JW'(JOINTS - 1))
    else $error("joint counter out of range");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE && q_valid))
    else $error("command taken outside idle");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/servo_move_interpolator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// servo_move_interpolator_top: timed linear move of servo joints
// Stage, start and tick transactions drive a linear joint move; each tick
// yields one pulse width per joint, or one idle status result.
// ----------------------------------------------------------------------------
// Transactions enter a four-entry command queue, so the input keeps accepting,
// until the queue is full, while the back end works or the result side stalls.
// Stage and start items are taken by the back end while idle and give no
// result; an idle tick gives one status result through the status state. A
// tick during a move is dispatched from idle, runs the bit-serial fraction
// divider unless the move has already run its duration, then walks each joint
// through interpolate multiply, clamp, span multiply, reciprocal multiply and
// emit; a stall on the result side holds the status and emit steps.
// ----------------------------------------------------------------------------
module servo_move_interpolator_top
  import smi_pkg::*;
#(
  parameter int JOINTS = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // item input
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           action,
  input  wire logic [2:0]           joint,
  input  wire logic signed [15:0]   angle,
  input  wire logic [15:0]          duration_ms,
  input  wire logic [31:0]          now_ms,
  // configuration
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  // results
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                joint_out,
  output logic [15:0]               pulse_us,
  output logic                      pulse_valid,
  output logic                      moving,
  output logic                      last
);

  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_valid;
  logic q_pop;
  cmd_t q_head;

  // Registers accept writes at any time outside reset
  assign cfg_ready = !rst;

  smi_front #(.JOINTS(JOINTS)) u_front (
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .joint       (joint),
    .angle       (angle),
    .duration_ms (duration_ms),
    .now_ms      (now_ms),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_in)
  );

  smi_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_in),
    .full       (q_full),
    .head_valid (q_valid),
    .pop        (q_pop),
    .head_cmd   (q_head)
  );

  smi_back #(.JOINTS(JOINTS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_head),
    .q_pop       (q_pop),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .joint_out   (joint_out),
    .pulse_us    (pulse_us),
    .pulse_valid (pulse_valid),
    .moving      (moving),
    .last        (last)
  );

endmodule
`default_nettype wire
